// ===== hdl/rbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsm_pkg
// Shared operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package rbsm_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_BLIND   = 2'd0;
    localparam t_op OP_SIGN    = 2'd1;
    localparam t_op OP_UNBLIND = 2'd2;
    localparam t_op OP_VERIFY  = 2'd3;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_MODULUS = 2'd0;
    localparam t_reg_idx REG_PUB_EXP = 2'd1;
    localparam t_reg_idx REG_PRV_EXP = 2'd2;

endpackage

// ===== hdl/rbsm_cell.sv =====
// ----------------------------------------------------------------------------
// rbsm_cell
// One bit cell of a shift chain: parallel load or take the neighbor's bit.
// ----------------------------------------------------------------------------
module rbsm_cell (
    input  logic i_clk,
    input  logic i_load,
    input  logic i_load_bit,
    input  logic i_shift,
    input  logic i_shift_bit,
    output logic o_bit
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bit <= i_load_bit;
        end else if (i_shift) begin
            r_bit <= i_shift_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// ===== hdl/rbsm_div.sv =====
// ----------------------------------------------------------------------------
// rbsm_div
// Bit-serial restoring divider producing quotient and remainder.
// ----------------------------------------------------------------------------
module rbsm_div #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot,
    output logic [WIDTH-1:0] o_rem
);

    localparam int CW = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_d;
    logic [WIDTH-1:0] w_bit;
    logic [WIDTH:0]   w_trial;
    logic             w_ge;
    logic [WIDTH:0]   w_next;

    assign w_trial = {r_rem, w_bit[WIDTH-1]};
    assign w_ge    = (w_trial >= {1'b0, r_d});
    assign w_next  = w_ge ? (w_trial - {1'b0, r_d}) : w_trial;

    genvar g;
    generate
        for (g = 0; g < WIDTH; g++) begin : g_cell
            rbsm_cell u_cell (
                .i_clk       (i_clk),
                .i_load      (i_start),
                .i_load_bit  (i_dividend[g]),
                .i_shift     (r_busy),
                .i_shift_bit ((g == 0) ? w_ge : w_bit[(g == 0) ? 0 : g-1]),
                .o_bit       (w_bit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_next[WIDTH-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = w_bit;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/rbsm_mul.sv =====
// ----------------------------------------------------------------------------
// rbsm_mul
// Bit-serial modular multiplier, double-and-add MSB first.
// ----------------------------------------------------------------------------
module rbsm_mul #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_n,
    output logic             o_done,
    output logic [WIDTH-1:0] o_prod
);

    localparam int CW = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_n;
    logic [WIDTH-1:0] w_bit;
    logic [WIDTH:0]   w_dbl;
    logic [WIDTH:0]   w_dbl_r;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH:0]   w_sum_r;

    assign w_dbl   = {r_acc, 1'b0};
    assign w_dbl_r = (w_dbl >= {1'b0, r_n}) ? (w_dbl - {1'b0, r_n}) : w_dbl;
    assign w_sum   = {1'b0, w_dbl_r[WIDTH-1:0]} + {1'b0, r_a};
    assign w_sum_r = (w_sum >= {1'b0, r_n}) ? (w_sum - {1'b0, r_n}) : w_sum;

    genvar g;
    generate
        for (g = 0; g < WIDTH; g++) begin : g_cell
            rbsm_cell u_cell (
                .i_clk       (i_clk),
                .i_load      (i_start),
                .i_load_bit  (i_b[g]),
                .i_shift     (r_busy),
                .i_shift_bit ((g == 0) ? 1'b0 : w_bit[(g == 0) ? 0 : g-1]),
                .o_bit       (w_bit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_n   <= i_n;
        end else if (r_busy) begin
            r_acc <= w_bit[WIDTH-1] ? w_sum_r[WIDTH-1:0] : w_dbl_r[WIDTH-1:0];
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/rsa_blind_signature_modular_unit.sv =====
// ----------------------------------------------------------------------------
// rsa_blind_signature_modular_unit
// Modular engine for RSA blind signatures: blind, sign, unblind, verify.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries operation, value, salt.
//   Output channel (o_out_valid / i_out_ready) returns result and status,
//   one transaction per input transaction, in order.
//   Config channel (i_cfg_valid / o_cfg_ready) writes modulus (0), public
//   exponent (1) and private exponent (2); other indexes are dropped.
// Datapath: every modular multiply or reduction runs on a bit-serial unit
//   that shifts its operand through a row of WIDTH bit cells, one bit per
//   cycle. A power takes WIDTH squarings plus one multiply per set exponent
//   bit. Unblind costs one divide and one multiply per Euclid step. One item
//   is processed at a time.
// Reset: registers return to modulus 35, both exponents 5; no item pending.
// Stall: a finished result sits in the output register; the next item is
//   accepted and worked on, and waits before finishing until it is taken.
// ----------------------------------------------------------------------------
module rsa_blind_signature_modular_unit #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_operation,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-1:0] i_salt,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_result,
    output logic             o_status,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [WIDTH-1:0] i_cfg_data
);

    localparam int CW = $clog2(WIDTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RV   = 4'd1;
    localparam logic [3:0] S_RS   = 4'd2;
    localparam logic [3:0] S_PSQ  = 4'd3;
    localparam logic [3:0] S_PMUL = 4'd4;
    localparam logic [3:0] S_FMUL = 4'd5;
    localparam logic [3:0] S_ECHK = 4'd6;
    localparam logic [3:0] S_EDIV = 4'd7;
    localparam logic [3:0] S_EMUL = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]       r_state, n_state;
    logic             r_go, n_go;
    logic [WIDTH-1:0] r_mod, r_pub, r_prv;
    rbsm_pkg::t_op    r_op, n_op;
    logic [WIDTH-1:0] r_val, n_val;
    logic [WIDTH-1:0] r_salt, n_salt;
    logic [WIDTH-1:0] r_v, n_v;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_base, n_base;
    logic [WIDTH-1:0] r_exp, n_exp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1;
    logic [WIDTH-1:0] r_q, n_q, r_rn, n_rn;
    logic [WIDTH-1:0] r_res, n_res;
    logic             r_stat, n_stat;
    logic             r_ovalid;
    logic [WIDTH-1:0] r_ores;
    logic             r_ostat;

    logic [WIDTH-1:0] w_one;
    logic             w_mul_done, w_div_done;
    logic [WIDTH-1:0] w_prod, w_quot, w_rem;
    logic [WIDTH-1:0] w_ma, w_mb, w_da, w_dd;
    logic             w_load_out;
    logic             w_accept;

    assign w_one      = (r_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    always_comb begin
        case (r_state)
            S_PSQ:   begin w_ma = r_acc;  w_mb = r_acc; end
            S_PMUL:  begin w_ma = r_base; w_mb = r_acc; end
            S_FMUL:  begin w_ma = r_v;    w_mb = r_acc; end
            default: begin w_ma = r_t1;   w_mb = r_q;   end
        endcase
        case (r_state)
            S_RV:    begin w_da = r_val;  w_dd = r_mod; end
            S_RS:    begin w_da = r_salt; w_dd = r_mod; end
            default: begin w_da = r_r0;   w_dd = r_r1;  end
        endcase
    end

    rbsm_mul #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state inside {S_PSQ, S_PMUL, S_FMUL, S_EMUL})),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .i_n     (r_mod),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    rbsm_div #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go && (r_state inside {S_RV, S_RS, S_EDIV})),
        .i_dividend (w_da),
        .i_divisor  (w_dd),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        n_op    = r_op;
        n_val   = r_val;
        n_salt  = r_salt;
        n_v     = r_v;
        n_acc   = r_acc;
        n_base  = r_base;
        n_exp   = r_exp;
        n_cnt   = r_cnt;
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_t0    = r_t0;
        n_t1    = r_t1;
        n_q     = r_q;
        n_rn    = r_rn;
        n_res   = r_res;
        n_stat  = r_stat;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op   = i_operation;
                    n_val  = i_value;
                    n_salt = i_salt;
                    n_res  = '0;
                    n_stat = 1'b0;
                    if (r_mod == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RV;
                        n_go    = 1'b1;
                    end
                end
            end
            S_RV: begin
                if (w_div_done) begin
                    n_v = w_rem;
                    if (r_op inside {rbsm_pkg::OP_BLIND, rbsm_pkg::OP_UNBLIND}) begin
                        n_state = S_RS;
                        n_go    = 1'b1;
                    end else begin
                        n_base  = w_rem;
                        n_acc   = w_one;
                        n_cnt   = '0;
                        n_exp   = (r_op == rbsm_pkg::OP_SIGN) ? r_prv : r_pub;
                        n_state = S_PSQ;
                        n_go    = 1'b1;
                    end
                end
            end
            S_RS: begin
                if (w_div_done) begin
                    if (r_op == rbsm_pkg::OP_BLIND) begin
                        n_base  = w_rem;
                        n_acc   = w_one;
                        n_cnt   = '0;
                        n_exp   = r_pub;
                        n_state = S_PSQ;
                        n_go    = 1'b1;
                    end else begin
                        n_r0    = r_mod;
                        n_r1    = w_rem;
                        n_t0    = '0;
                        n_t1    = w_one;
                        n_state = S_ECHK;
                    end
                end
            end
            S_PSQ, S_PMUL: begin
                if (w_mul_done) begin
                    n_acc = w_prod;
                    if (r_state == S_PSQ && r_exp[WIDTH-1]) begin
                        n_state = S_PMUL;
                        n_go    = 1'b1;
                    end else begin
                        n_exp = {r_exp[WIDTH-2:0], 1'b0};
                        n_cnt = r_cnt + 1'b1;
                        n_go  = 1'b1;
                        if (r_cnt == CW'(WIDTH-1)) begin
                            if (r_op == rbsm_pkg::OP_BLIND) begin
                                n_state = S_FMUL;
                            end else begin
                                n_res   = w_prod;
                                n_state = S_DONE;
                                n_go    = 1'b0;
                            end
                        end else begin
                            n_state = S_PSQ;
                        end
                    end
                end
            end
            S_FMUL: begin
                if (w_mul_done) begin
                    n_res   = w_prod;
                    n_state = S_DONE;
                end
            end
            S_ECHK: begin
                if (r_r1 == '0) begin
                    if (r_r0 == WIDTH'(1)) begin
                        n_acc   = r_t0;
                        n_state = S_FMUL;
                        n_go    = 1'b1;
                    end else begin
                        n_res   = '0;
                        n_stat  = 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_EDIV;
                    n_go    = 1'b1;
                end
            end
            S_EDIV: begin
                if (w_div_done) begin
                    n_q     = (w_quot >= r_mod) ? (w_quot - r_mod) : w_quot;
                    n_rn    = w_rem;
                    n_state = S_EMUL;
                    n_go    = 1'b1;
                end
            end
            S_EMUL: begin
                if (w_mul_done) begin
                    n_t1    = (r_t0 >= w_prod) ? (r_t0 - w_prod)
                                               : (r_t0 + (r_mod - w_prod));
                    n_t0    = r_t1;
                    n_r0    = r_r1;
                    n_r1    = r_rn;
                    n_state = S_ECHK;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
            r_mod    <= WIDTH'(35);
            r_pub    <= WIDTH'(5);
            r_prv    <= WIDTH'(5);
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rbsm_pkg::REG_MODULUS: r_mod <= i_cfg_data;
                    rbsm_pkg::REG_PUB_EXP: r_pub <= i_cfg_data;
                    rbsm_pkg::REG_PRV_EXP: r_prv <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_val  <= n_val;
        r_salt <= n_salt;
        r_v    <= n_v;
        r_acc  <= n_acc;
        r_base <= n_base;
        r_exp  <= n_exp;
        r_cnt  <= n_cnt;
        r_r0   <= n_r0;
        r_r1   <= n_r1;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_q    <= n_q;
        r_rn   <= n_rn;
        r_res  <= n_res;
        r_stat <= n_stat;
        if (w_load_out) begin
            r_ores  <= r_res;
            r_ostat <= r_stat;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_result    = r_ores;
    assign o_status    = r_ostat;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== hdl/rbsm_checker.sv =====
// ----------------------------------------------------------------------------
// rbsm_checker
// Port-level checks for the blind signature unit, bound to the top level.
// ----------------------------------------------------------------------------
module rbsm_checker #(
    parameter int WIDTH = 32
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [WIDTH-1:0] o_result,
    input logic             o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result) && $stable(o_status))
        else $error("output payload changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_result == '0)
        else $error("error status with nonzero result");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction accepted while busy");

endmodule

bind rsa_blind_signature_modular_unit rbsm_checker #(.WIDTH(WIDTH)) u_rbsm_checker (.*);
